// ===== hw/rtl/hrlp_pkg.sv =====
// Shared types and constants for the HTTP request line parser.
`default_nettype none

package hrlp_pkg;

    localparam int PATH_LIMIT    = 256;
    localparam int REQUEST_LIMIT = 4096;
    localparam int PATH_CNT_W    = $clog2(PATH_LIMIT + 1);
    localparam int BYTE_CNT_W    = $clog2(REQUEST_LIMIT + 1);

    localparam logic [7:0]  BYTE_NUL  = 8'h00;
    localparam logic [7:0]  BYTE_TAB  = 8'h09;
    localparam logic [7:0]  BYTE_LF   = 8'h0A;
    localparam logic [7:0]  BYTE_CR   = 8'h0D;
    localparam logic [7:0]  BYTE_SP   = 8'h20;
    localparam logic [23:0] WORD_GET  = 24'h474554;
    localparam logic [31:0] WORD_POST = 32'h504F5354;

    typedef enum logic [1:0] {
        KIND_PATH    = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_END     = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_METHOD  = 2'd1,
        ST_BAD_METHOD = 2'd2,
        ST_NO_PATH    = 2'd3
    } t_status;

    localparam logic METHOD_GET  = 1'b0;
    localparam logic METHOD_POST = 1'b1;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        logic       done_res;
        t_status    status;
        logic       method_code;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/hrlp_req_if.sv =====
// Request byte channel: valid, ready and one raw request byte.
`default_nettype none

interface hrlp_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_request;

    modport source (output valid, output data_byte, output end_of_request, input ready);
    modport sink (input valid, input data_byte, input end_of_request, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hrlp_res_if.sv =====
// Result channel: valid, ready and one parsed result item.
`default_nettype none

interface hrlp_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       done_res;
    logic [1:0] status;
    logic       method_code;

    modport source (output valid, output kind, output out_byte, output done_res,
                    output status, output method_code, input ready);
    modport sink (input valid, input kind, input out_byte, input done_res,
                  input status, input method_code, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hrlp_core.sv =====
// Parser state and per-byte decision logic.
`default_nettype none

module hrlp_core import hrlp_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    hrlp_req_if.sink     i_req,
    input  wire logic    i_space,
    output logic         o_push,
    output t_result      o_result
);

    typedef enum logic [2:0] {
        PH_SKIP_METHOD = 3'd0,
        PH_METHOD      = 3'd1,
        PH_SKIP_PATH   = 3'd2,
        PH_PATH        = 3'd3,
        PH_OK          = 3'd4,
        PH_NO_METHOD   = 3'd5,
        PH_BAD_METHOD  = 3'd6,
        PH_NO_PATH     = 3'd7
    } t_phase;

    localparam logic [1:0] MK_NONE = 2'd0;
    localparam logic [1:0] MK_GET  = 2'd1;
    localparam logic [1:0] MK_POST = 2'd2;

    t_phase                r_phase, n_phase;
    logic [31:0]           r_shift, n_shift;
    logic [2:0]            r_len, n_len;
    logic [PATH_CNT_W-1:0] r_path_count, n_path_count;
    logic [1:0]            r_term, n_term;
    logic                  r_payload, n_payload;
    logic [BYTE_CNT_W-1:0] r_byte_count, n_byte_count;

    logic       accept;
    logic       has_kind;
    logic [7:0] b;
    logic [7:0] eff;
    logic [7:0] pat;
    logic [1:0] mk_cur;
    logic [1:0] mk_next;
    t_result    res;

    function automatic logic is_space(input logic [7:0] v);
        return v == BYTE_SP || v == BYTE_TAB || v == BYTE_CR || v == BYTE_LF;
    endfunction

    function automatic logic [1:0] method_kind(input logic [31:0] sh, input logic [2:0] len);
        logic [1:0] mk;
        mk = MK_NONE;
        if (len == 3'd3 && sh[23:0] == WORD_GET) mk = MK_GET;
        else if (len == 3'd4 && sh == WORD_POST) mk = MK_POST;
        return mk;
    endfunction

    assign accept      = i_req.valid && i_space;
    assign i_req.ready = i_space;
    assign b           = i_req.data_byte;
    assign mk_cur      = method_kind(r_shift, r_len);
    assign pat         = r_term[0] ? BYTE_LF : BYTE_CR;

    always_comb begin
        n_phase      = r_phase;
        n_shift      = r_shift;
        n_len        = r_len;
        n_path_count = r_path_count;
        n_term       = r_term;
        n_payload    = r_payload;
        n_byte_count = r_byte_count;
        eff          = b;
        has_kind     = 1'b0;
        res          = '{kind: KIND_END, out_byte: 8'h00, done_res: 1'b0,
                         status: ST_OK, method_code: METHOD_GET};
        mk_next      = MK_NONE;

        if (r_byte_count < BYTE_CNT_W'(REQUEST_LIMIT)) begin
            n_byte_count = r_byte_count + 1'b1;
            unique case (r_phase)
                PH_SKIP_METHOD: begin
                    if (b == BYTE_NUL) n_phase = PH_NO_METHOD;
                    else if (!is_space(b)) begin
                        n_shift = {24'h000000, b};
                        n_len   = 3'd1;
                        n_phase = PH_METHOD;
                    end
                end
                PH_METHOD: begin
                    if (b == BYTE_NUL || is_space(b)) begin
                        eff = BYTE_NUL;
                        if (mk_cur == MK_NONE) n_phase = PH_BAD_METHOD;
                        else n_phase = (b == BYTE_NUL) ? PH_NO_PATH : PH_SKIP_PATH;
                    end else begin
                        n_shift = {r_shift[23:0], b};
                        if (r_len != 3'd7) n_len = r_len + 1'b1;
                    end
                end
                PH_SKIP_PATH: begin
                    if (b == BYTE_NUL) n_phase = PH_NO_PATH;
                    else if (!is_space(b)) begin
                        has_kind     = 1'b1;
                        res.kind     = KIND_PATH;
                        res.out_byte = b;
                        n_path_count = PATH_CNT_W'(1);
                        n_phase      = PH_PATH;
                    end
                end
                PH_PATH: begin
                    if (b == BYTE_NUL || is_space(b)) begin
                        eff     = BYTE_NUL;
                        n_phase = PH_OK;
                    end else if (r_path_count < PATH_CNT_W'(PATH_LIMIT)) begin
                        has_kind     = 1'b1;
                        res.kind     = KIND_PATH;
                        res.out_byte = b;
                        n_path_count = r_path_count + 1'b1;
                    end
                end
                default: ;
            endcase

            if (r_payload) begin
                if (!has_kind) begin
                    has_kind     = 1'b1;
                    res.kind     = KIND_PAYLOAD;
                    res.out_byte = eff;
                end
            end else if (eff == pat) begin
                if (r_term == 2'd3) begin
                    n_payload = 1'b1;
                    n_term    = 2'd0;
                end else begin
                    n_term = r_term + 1'b1;
                end
            end else begin
                n_term = (eff == BYTE_CR) ? 2'd1 : 2'd0;
            end
        end

        if (i_req.end_of_request) begin
            mk_next      = method_kind(n_shift, n_len);
            res.done_res = 1'b1;
            unique case (n_phase)
                PH_SKIP_METHOD: res.status = ST_NO_METHOD;
                PH_METHOD:      res.status = (mk_next == MK_NONE) ? ST_BAD_METHOD : ST_NO_PATH;
                PH_SKIP_PATH:   res.status = ST_NO_PATH;
                PH_PATH:        res.status = ST_OK;
                PH_OK:          res.status = ST_OK;
                PH_NO_METHOD:   res.status = ST_NO_METHOD;
                PH_BAD_METHOD:  res.status = ST_BAD_METHOD;
                PH_NO_PATH:     res.status = ST_NO_PATH;
                default:        res.status = ST_NO_PATH;
            endcase
            if (res.status == ST_OK && mk_next == MK_POST) res.method_code = METHOD_POST;
            n_phase      = PH_SKIP_METHOD;
            n_shift      = 32'h0;
            n_len        = 3'd0;
            n_path_count = '0;
            n_term       = 2'd0;
            n_payload    = 1'b0;
            n_byte_count = '0;
        end
    end

    assign o_push   = accept && (has_kind || i_req.end_of_request);
    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SKIP_METHOD;
            r_shift      <= 32'h0;
            r_len        <= 3'd0;
            r_path_count <= '0;
            r_term       <= 2'd0;
            r_payload    <= 1'b0;
            r_byte_count <= '0;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_shift      <= n_shift;
            r_len        <= n_len;
            r_path_count <= n_path_count;
            r_term       <= n_term;
            r_payload    <= n_payload;
            r_byte_count <= n_byte_count;
        end
    end

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req.end_of_request |=> r_phase == PH_SKIP_METHOD && r_byte_count == '0)
        else $error("parser state not cleared after last request byte");

    a_end_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_result.kind == KIND_END |-> o_result.done_res)
        else $error("end marker without done");

    a_method_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_result.method_code |-> o_result.done_res && o_result.status == ST_OK)
        else $error("method code set without ok status");

    a_path_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_path_count <= PATH_CNT_W'(PATH_LIMIT))
        else $error("path count beyond limit");

endmodule

`default_nettype wire

// ===== hw/rtl/hrlp_out_buf.sv =====
// Two-entry skid buffer between the parser and the result channel.
`default_nettype none

module hrlp_out_buf import hrlp_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_result,
    output logic         o_space,
    hrlp_res_if.source   o_res
);

    logic    r_valid;
    logic    r_sk_valid;
    t_result r_data;
    t_result r_sk_data;
    logic    pop;

    assign o_space = !r_sk_valid;
    assign pop     = r_valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (pop) begin
            if (r_sk_valid) begin
                r_data     <= r_sk_data;
                r_sk_valid <= 1'b0;
            end else if (i_push) begin
                r_data <= i_result;
            end else begin
                r_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_valid) begin
                r_data  <= i_result;
                r_valid <= 1'b1;
            end else begin
                r_sk_data  <= i_result;
                r_sk_valid <= 1'b1;
            end
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.kind        = r_data.kind;
    assign o_res.out_byte    = r_data.out_byte;
    assign o_res.done_res    = r_data.done_res;
    assign o_res.status      = r_data.status;
    assign o_res.method_code = r_data.method_code;

endmodule

`default_nettype wire

// ===== hw/rtl/http_request_line_parser_unit.sv =====
// Top level of the HTTP request line parser.
// Each result is registered in the output buffer when its request byte is accepted.
// One request byte per cycle while the skid entry is free; parser state updates per accepted byte.
// A two-entry skid buffer on the result side keeps input ready while a result waits.
// Reset (synchronous, active low) returns the parser to method skipping and empties the buffer.
// After the last byte of a request the parser returns to its reset state.
`default_nettype none

module http_request_line_parser_unit import hrlp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hrlp_req_if.sink   i_req,
    hrlp_res_if.source o_res
);

    logic    space;
    logic    push;
    t_result result;

    hrlp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_space  (space),
        .o_push   (push),
        .o_result (result)
    );

    hrlp_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (result),
        .o_space  (space),
        .o_res    (o_res)
    );

endmodule

`default_nettype wire

// ===== tb/tb_http_request_line_parser_unit.sv =====
// Self-checking testbench for the HTTP request line parser: directed and random requests.
`default_nettype none

module tb_http_request_line_parser_unit import hrlp_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BYTES = 460;

    typedef enum logic [2:0] {
        PH_SKIP_METHOD,
        PH_METHOD,
        PH_SKIP_PATH,
        PH_PATH,
        PH_PATH_DONE,
        PH_NO_METHOD,
        PH_BAD_METHOD,
        PH_NO_PATH
    } t_parse_phase;

    typedef enum logic [1:0] {
        MK_NONE,
        MK_GET,
        MK_POST
    } t_method_kind;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hrlp_req_if req_if();
    hrlp_res_if res_if();

    http_request_line_parser_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_result      pending_results[$];
    logic [7:0]   req_buf[$];
    int           fail_count = 0;
    int           cycle_count = 0;
    bit           src_idle_en = 1'b1;
    bit           snk_idle_en = 1'b1;

    t_parse_phase parse_phase;
    logic [31:0]  method_shift;
    logic [2:0]   method_len;
    int           path_count;
    logic [1:0]   crlf_progress;
    logic         in_payload;
    int           taken_bytes;

    function automatic logic is_ws(input logic [7:0] b);
        return b == BYTE_SP || b == BYTE_TAB || b == BYTE_CR || b == BYTE_LF;
    endfunction

    function automatic t_method_kind method_of();
        if (method_len == 3'd3 && method_shift[23:0] == WORD_GET) return MK_GET;
        if (method_len == 3'd4 && method_shift == WORD_POST) return MK_POST;
        return MK_NONE;
    endfunction

    task automatic restart_parser();
        parse_phase   = PH_SKIP_METHOD;
        method_shift  = '0;
        method_len    = '0;
        path_count    = 0;
        crlf_progress = '0;
        in_payload    = 1'b0;
        taken_bytes   = 0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        t_result    r;
        logic       emit;
        logic       was_payload;
        logic [7:0] eff;
        emit          = 1'b0;
        eff           = b;
        r.kind        = KIND_END;
        r.out_byte    = 8'h00;
        r.done_res    = 1'b0;
        r.status      = ST_OK;
        r.method_code = METHOD_GET;
        if (taken_bytes < REQUEST_LIMIT) begin
            was_payload = in_payload;
            taken_bytes++;
            case (parse_phase)
                PH_SKIP_METHOD: begin
                    if (b == BYTE_NUL) begin
                        parse_phase = PH_NO_METHOD;
                    end else if (!is_ws(b)) begin
                        method_shift = {24'h0, b};
                        method_len   = 3'd1;
                        parse_phase  = PH_METHOD;
                    end
                end
                PH_METHOD: begin
                    if (b == BYTE_NUL || is_ws(b)) begin
                        eff = BYTE_NUL;
                        if (method_of() == MK_NONE) parse_phase = PH_BAD_METHOD;
                        else parse_phase = (b == BYTE_NUL) ? PH_NO_PATH : PH_SKIP_PATH;
                    end else begin
                        method_shift = {method_shift[23:0], b};
                        if (method_len < 3'd7) method_len++;
                    end
                end
                PH_SKIP_PATH: begin
                    if (b == BYTE_NUL) begin
                        parse_phase = PH_NO_PATH;
                    end else if (!is_ws(b)) begin
                        emit        = 1'b1;
                        r.kind      = KIND_PATH;
                        r.out_byte  = b;
                        path_count  = 1;
                        parse_phase = PH_PATH;
                    end
                end
                PH_PATH: begin
                    if (b == BYTE_NUL || is_ws(b)) begin
                        eff         = BYTE_NUL;
                        parse_phase = PH_PATH_DONE;
                    end else if (path_count < PATH_LIMIT) begin
                        emit       = 1'b1;
                        r.kind     = KIND_PATH;
                        r.out_byte = b;
                        path_count++;
                    end
                end
                default: ;
            endcase
            if (was_payload) begin
                if (!emit) begin
                    emit       = 1'b1;
                    r.kind     = KIND_PAYLOAD;
                    r.out_byte = eff;
                end
            end else if (eff == (crlf_progress[0] ? BYTE_LF : BYTE_CR)) begin
                if (crlf_progress == 2'd3) begin
                    in_payload    = 1'b1;
                    crlf_progress = 2'd0;
                end else begin
                    crlf_progress++;
                end
            end else begin
                crlf_progress = (eff == BYTE_CR) ? 2'd1 : 2'd0;
            end
        end
        if (last) begin
            emit       = 1'b1;
            r.done_res = 1'b1;
            case (parse_phase)
                PH_SKIP_METHOD: r.status = ST_NO_METHOD;
                PH_METHOD:      r.status = (method_of() == MK_NONE) ? ST_BAD_METHOD : ST_NO_PATH;
                PH_SKIP_PATH:   r.status = ST_NO_PATH;
                PH_PATH:        r.status = ST_OK;
                PH_PATH_DONE:   r.status = ST_OK;
                PH_NO_METHOD:   r.status = ST_NO_METHOD;
                PH_BAD_METHOD:  r.status = ST_BAD_METHOD;
                default:        r.status = ST_NO_PATH;
            endcase
            if (r.status == ST_OK && method_of() == MK_POST) r.method_code = METHOD_POST;
            restart_parser();
        end
        if (emit) pending_results.push_back(r);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 3))
            0: return BYTE_SP;
            1: return BYTE_TAB;
            2: return BYTE_CR;
            default: return BYTE_LF;
        endcase
    endfunction

    function automatic logic [7:0] pick_noise_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return pick_ws();
        if (r < 28) return BYTE_NUL;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_path_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (is_ws(b));
        return b;
    endfunction

    function automatic logic [7:0] pick_letter();
        return 8'h41 + 8'($urandom_range(0, 25));
    endfunction

    task automatic push_byte(input logic [7:0] b);
        req_buf.push_back(b);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) req_buf.push_back(s[i]);
    endtask

    task automatic push_method();
        if ($urandom_range(0, 1)) push_str("POST");
        else push_str("GET");
    endtask

    task automatic push_crlf();
        req_buf.push_back(BYTE_CR);
        req_buf.push_back(BYTE_LF);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = (src_idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.data_byte      <= b;
        req_if.end_of_request <= last;
        do @(posedge i_clk); while (!req_if.ready);
        parse_byte(b, last);
    endtask

    task automatic send_request();
        for (int i = 0; i < req_buf.size(); i++) send_byte(req_buf[i], i == req_buf.size() - 1);
        req_buf.delete();
    endtask

    task automatic wait_results_drained();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic test_directed();
        push_byte(BYTE_NUL);
        send_request();
        push_byte(BYTE_SP);
        send_request();
        // hold an unknown and a valid method open up to the last byte
        push_str("PUT");
        send_request();
        push_str("GET");
        send_request();
        push_str("POST");
        push_byte(BYTE_NUL);
        send_request();
        // terminator inside the leading whitespace
        push_crlf();
        push_crlf();
        push_str("GET");
        push_byte(BYTE_SP);
        push_byte(8'hFF);
        send_request();
        push_str("POST a");
        push_crlf();
        push_crlf();
        push_crlf();
        push_byte(8'hFF);
        push_byte(BYTE_NUL);
        send_request();
        wait_results_drained();
    endtask

    task automatic test_path_limit();
        push_str("GET ");
        repeat (PATH_LIMIT + 40) push_byte(pick_path_byte());
        push_byte(BYTE_SP);
        push_crlf();
        push_crlf();
        push_str("xy");
        send_request();
        wait_results_drained();
    endtask

    task automatic test_random_requests();
        int sent;
        int n_req;
        int shape;
        int n;
        sent  = 0;
        n_req = 0;
        while (sent < RANDOM_BYTES) begin
            n_req++;
            src_idle_en = ($urandom_range(0, 99) >= 15);
            snk_idle_en = src_idle_en;
            shape = $urandom_range(0, 99);
            if (shape < 10) begin
                repeat ($urandom_range(1, 8)) push_byte(pick_noise_byte());
            end else begin
                repeat ($urandom_range(0, 3)) push_byte(pick_ws());
                n = $urandom_range(0, 99);
                if (n < 80) begin
                    push_method();
                end else if (n < 90) begin
                    repeat ($urandom_range(1, 9)) push_byte(pick_letter());
                end else begin
                    repeat ($urandom_range(1, 4)) push_byte(pick_letter());
                    push_method();
                end
                repeat ($urandom_range(1, 2)) push_byte(($urandom_range(0, 1)) ? BYTE_SP : BYTE_TAB);
                repeat ($urandom_range(1, 12)) push_byte(pick_path_byte());
                if ($urandom_range(0, 1)) push_str(" HTTP/1.1");
                push_crlf();
                if ($urandom_range(0, 1)) begin
                    push_str("A: b");
                    push_crlf();
                end
                if ($urandom_range(0, 99) < 85) begin
                    push_crlf();
                    repeat ($urandom_range(0, 10)) push_byte(8'($urandom_range(0, 255)));
                end
                // break some requests: cut short or corrupt one byte
                if (shape < 20) begin
                    n = $urandom_range(1, req_buf.size());
                    while (req_buf.size() > n) void'(req_buf.pop_back());
                end else if (shape < 26) begin
                    req_buf[$urandom_range(0, req_buf.size() - 1)] = pick_noise_byte();
                end
            end
            sent += req_buf.size();
            send_request();
            if (n_req % 10 == 0) wait_results_drained();
        end
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    initial begin
        int stall;
        stall = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                stall--;
                res_if.ready <= 1'b0;
            end else if (snk_idle_en && $urandom_range(0, 3) == 0) begin
                stall = pick_gap() - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d out_byte 0x%02h", res_if.kind, res_if.out_byte);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (res_if.kind !== exp_r.kind) begin
                    $error("kind: expected %0d, got %0d", exp_r.kind, res_if.kind);
                    fail_count++;
                end
                if (res_if.out_byte !== exp_r.out_byte) begin
                    $error("out_byte: expected 0x%02h, got 0x%02h", exp_r.out_byte,
                           res_if.out_byte);
                    fail_count++;
                end
                if (res_if.done_res !== exp_r.done_res) begin
                    $error("done_res: expected %0d, got %0d", exp_r.done_res, res_if.done_res);
                    fail_count++;
                end
                if (res_if.status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, res_if.status);
                    fail_count++;
                end
                if (res_if.method_code !== exp_r.method_code) begin
                    $error("method_code: expected %0d, got %0d", exp_r.method_code,
                           res_if.method_code);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        req_if.valid          <= 1'b0;
        req_if.data_byte      <= 8'h00;
        req_if.end_of_request <= 1'b0;
        restart_parser();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_path_limit();
        test_random_requests();

        wait_results_drained();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
